/* sv/mh3_pkg.sv */
// ----------------------------------------------------------------------------
// mh3_pkg
// shared types and constants of the murmur3 bucket indexer
// ----------------------------------------------------------------------------
package mh3_pkg;

	localparam logic [31:0] MIX_C1       = 32'hcc9e2d51;
	localparam logic [31:0] MIX_C2       = 32'h1b873593;
	localparam logic [31:0] MIX_N        = 32'he6546b64;
	localparam logic [31:0] FMIX_A       = 32'h85ebca6b;
	localparam logic [31:0] FMIX_B       = 32'hc2b2ae35;
	localparam logic [31:0] BUCKET_COUNT = 32'd10000007;

	// floor(h / BUCKET_COUNT) is approximated as (h * RECIP_M) >> RECIP_SHIFT,
	// which is never more than one below the true quotient
	localparam int unsigned RECIP_SHIFT = 55;
	localparam logic [63:0] RECIP_M     = (64'd1 << RECIP_SHIFT) / 64'(BUCKET_COUNT);
	localparam int unsigned QUOT_W      = 9;

	// op queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// register byte addresses
	localparam logic [2:0] ADDR_HASH_SEED = 3'd0;

	typedef struct packed {
		logic [31:0] key_word;
		logic [2:0]  bytes_valid;
		logic        is_last;
	} in_item_t;

	typedef struct packed {
		logic [31:0] raw_hash;
		logic [23:0] bucket_index;
	} out_item_t;

	// classified and pre-scrambled word passed from front to back
	typedef struct packed {
		logic [31:0] k;
		logic [2:0]  nbytes;
		logic        last;
	} mh3_op_t;

	localparam logic [2:0] NB_NONE = 3'd0;
	localparam logic [2:0] NB_FULL = 3'd4;

	typedef struct packed {
		logic full;
		logic empty;
		logic [QCNT_W-1:0] count;
	} mh3_qstat_t;

endpackage

/* sv/mh3_front.sv */
// ----------------------------------------------------------------------------
// mh3_front
// accepts key words, clamps the byte count, masks the tail and scrambles
// ----------------------------------------------------------------------------
module mh3_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  mh3_pkg::in_item_t in_item,
	input  logic              q_full,
	output logic              push,
	output mh3_pkg::mh3_op_t  push_op
);
	import mh3_pkg::*;

	logic        adv;
	logic [2:0]  nb;
	logic [31:0] mask;
	logic        valid_s1, valid_s2;
	logic [31:0] k_s1, k_s2, rot;
	logic [2:0]  nb_s1, nb_s2;
	logic        last_s1, last_s2;

	// the whole front moves together; it holds only when a finished op cannot be queued
	assign adv      = !valid_s2 || !q_full;
	assign in_stall = !adv;

	always_comb begin
		if (!in_item.is_last || in_item.bytes_valid > NB_FULL)
			nb = NB_FULL;
		else
			nb = in_item.bytes_valid;
		case (nb)
			3'd1:    mask = 32'h0000_00ff;
			3'd2:    mask = 32'h0000_ffff;
			3'd3:    mask = 32'h00ff_ffff;
			default: mask = 32'hffff_ffff;
		endcase
	end

	assign rot = {k_s1[16:0], k_s1[31:17]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			k_s1    <= (in_item.key_word & mask) * MIX_C1;
			nb_s1   <= nb;
			last_s1 <= in_item.is_last;
			k_s2    <= rot * MIX_C2;
			nb_s2   <= nb_s1;
			last_s2 <= last_s1;
		end
	end

	assign push           = valid_s2 && !q_full;
	assign push_op.k      = k_s2;
	assign push_op.nbytes = nb_s2;
	assign push_op.last   = last_s2;

endmodule

/* sv/mh3_queue.sv */
// ----------------------------------------------------------------------------
// mh3_queue
// small fifo of scrambled ops between front and back
// ----------------------------------------------------------------------------
module mh3_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mh3_pkg::mh3_op_t    push_op,
	input  logic                pop,
	output mh3_pkg::mh3_op_t    pop_op,
	output mh3_pkg::mh3_qstat_t stat
);
	import mh3_pkg::*;

	localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CntW = QCNT_W;

	mh3_op_t         mem_q [QUEUE_DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_op;
	end

	assign pop_op     = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == CntW'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.count = count_q;

endmodule

/* sv/mh3_back.sv */
// ----------------------------------------------------------------------------
// mh3_back
// running hash update, finalization mix and bucket reduction
// ----------------------------------------------------------------------------
module mh3_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [31:0]        seed,
	input  logic               seed_load,
	input  logic               q_empty,
	input  mh3_pkg::mh3_op_t   op,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output mh3_pkg::out_item_t out_item
);
	import mh3_pkg::*;

	logic        adv;
	logic [31:0] acc_q, total_q, acc_next, total_next, mixed, rot, x0, x1, y, raw;
	logic [31:0] f_s1, f_s2, raw_s3, raw_s4, raw_s5, qc_s5, rem, rem_c;
	logic [63:0] prod_s4;
	logic        v_s1, v_s2, v_s3, v_s4, v_s5, out_valid_q;
	out_item_t   out_q;

	assign adv = !out_valid_q || !out_stall;
	assign pop = adv && !q_empty;

	// block mix: rotl13 then times five plus constant
	assign mixed = acc_q ^ op.k;
	assign rot   = {mixed[18:0], mixed[31:19]};

	always_comb begin
		case (op.nbytes)
			NB_FULL:             acc_next = (rot << 2) + rot + MIX_N;
			3'd1, 3'd2, 3'd3:    acc_next = mixed;
			default:             acc_next = acc_q;
		endcase
		total_next = total_q + 32'(op.nbytes);
		x0 = acc_next ^ total_next;
		x1 = x0 ^ (x0 >> 16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			total_q <= '0;
		end else if (seed_load) begin
			acc_q   <= seed;
			total_q <= '0;
		end else if (pop) begin
			acc_q   <= op.last ? seed  : acc_next;
			total_q <= op.last ? '0    : total_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= pop && op.last;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	assign y   = f_s1 ^ (f_s1 >> 13);
	assign raw = f_s2 ^ (f_s2 >> 16);

	// quotient estimate is low by at most one, so a single correction suffices
	assign rem   = raw_s5 - qc_s5;
	assign rem_c = (rem >= BUCKET_COUNT) ? rem - BUCKET_COUNT : rem;

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s1    <= x1 * FMIX_A;
			f_s2    <= y * FMIX_B;
			raw_s3  <= raw;
			raw_s4  <= raw_s3;
			prod_s4 <= {32'd0, raw_s3} * RECIP_M;
			raw_s5  <= raw_s4;
			qc_s5   <= 32'(prod_s4[RECIP_SHIFT +: QUOT_W]) * BUCKET_COUNT;
			out_q.raw_hash     <= raw_s5;
			out_q.bucket_index <= rem_c[23:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

/* sv/murmur3_hash_bucket_index_top.sv */
// ----------------------------------------------------------------------------
// murmur3_hash_bucket_index_top
// streaming murmurhash3 x86_32 of a key, with the hash reduced mod 10000007
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid / in_stall / in_item): one little-endian key word per
//   item; is_last closes the key, bytes_valid 0..4 sets its size (earlier
//   items always count as four bytes)
//   out channel (out_valid / out_stall / out_item): one item per key with the
//   raw hash and the bucket index
//   apb port: register 0 at byte address 0 is hash_seed; writing it reloads
//   the running hash and clears the byte count, so write it only when idle
// path: a last input item passes the front stages, the op queue, the back stages and the output register
// throughput: one input item per cycle while in_stall is low; the running hash update (xor, rotate,
//   times five and add) is computed combinationally from the registered running hash in the back end
// reset: seed, running hash and byte count clear to zero, the op queue empties
// stall: a stalled result freezes the back end; the op queue then fills and
//   the front end raises in_stall once it holds a finished op it cannot queue
// ----------------------------------------------------------------------------
module murmur3_hash_bucket_index_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  mh3_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output mh3_pkg::out_item_t out_item,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import mh3_pkg::*;

	logic        seed_load;
	logic [31:0] seed_q;
	logic [31:0] seed_now;
	logic        push, pop;
	mh3_op_t     push_op, pop_op;
	mh3_qstat_t  q_stat;

	// config register: only one, decoded on the word address bit
	assign pready    = 1'b1;
	assign seed_load = psel && penable && pwrite && (paddr[2] == ADDR_HASH_SEED[2]);
	assign prdata    = (paddr[2] == ADDR_HASH_SEED[2]) ? seed_q : 32'd0;

	// seed seen by the back end: the new value in the write cycle, else the register
	assign seed_now  = seed_load ? pwdata : seed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seed_q <= '0;
		else if (seed_load)
			seed_q <= pwdata;
	end

	// front end: clamp byte count, mask tail bytes, scramble the word
	mh3_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_full   (q_stat.full),
		.push     (push),
		.push_op  (push_op)
	);

	// decoupling queue between front and back
	mh3_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.pop_op  (pop_op),
		.stat    (q_stat)
	);

	// back end: running hash, fmix32 and bucket reduction
	mh3_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed      (seed_now),
		.seed_load (seed_load),
		.q_empty   (q_stat.empty),
		.op        (pop_op),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

`ifndef SYNTHESIS
	// the queue can never report full and empty together
	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("op queue full and empty at once");

	// fill level stays within depth
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= QCNT_W'(QUEUE_DEPTH))
		else $error("op queue overfilled");

	// the bucket reduction always ends below the bucket count
	a_bucket_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(out_item.bucket_index) < BUCKET_COUNT))
		else $error("bucket index out of range");

	// the front only stalls while the queue is full
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_stat.full)
		else $error("input stalled with room in the queue");
`endif

endmodule
